// ----- rtl/servo_slew_limited_interpolator_assert.svh -----
// Assertion macros shared by the interpolator checker.
// Depends on nothing; expects clk and rst_n in the including scope.
`ifndef SERVO_SLEW_LIMITED_INTERPOLATOR_ASSERT_SVH
`define SERVO_SLEW_LIMITED_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SSLI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSLI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ssli_pkg.sv -----
// Shared types, constants and helpers of the slew-limited servo interpolator.
// No dependencies.
package ssli_pkg;

  localparam int AXES          = 6;
  localparam int MAX_SUBSTEPS  = 32;
  localparam int PULSE_MIN     = 450;
  localparam int PULSE_MAX     = 2300;
  localparam int BASE_SAFE_MIN = 500;
  localparam int BASE_SAFE_MAX = 2500;
  localparam int FULL_TENTHS   = 1800;
  localparam int HOME_TENTHS   = 900;

  localparam int ANG_W   = 11;
  localparam int PULSE_W = 12;
  localparam int SUB_W   = 6;
  localparam int FRM_W   = $clog2(MAX_SUBSTEPS + 1);
  localparam int AXIS_W  = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int SPAN_W  = ANG_W + 3;
  localparam int DIV_NW  = ANG_W + PULSE_W;
  localparam int DIV_DW  = ANG_W;
  localparam int IDX_W   = 3;

  typedef logic [ANG_W-1:0]   angle_t;
  typedef logic [PULSE_W-1:0] pulse_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MAX_STEP,
    REG_SUBSTEP_COUNT,
    REG_REVERSE_DEADBAND,
    REG_BASE_ANGLE_MIN,
    REG_BASE_ANGLE_MAX,
    REG_BASE_PULSE_AT_MIN,
    REG_BASE_PULSE_AT_MAX
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIR_NONE,
    DIR_UP,
    DIR_DOWN
  } dir_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAN,
    ST_INTERP,
    ST_INTERP_WAIT,
    ST_PULSE,
    ST_PULSE_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    angle_t max_step;
    angle_t reverse_deadband;
    angle_t base_angle_min;
    angle_t base_angle_max;
    pulse_t base_pulse_at_min;
    pulse_t base_pulse_at_max;
  } cfg_t;

  typedef struct packed {
    logic              accept;
    logic              plan_en;
    logic              interp_start;
    logic              interp_commit;
    logic              pulse_start;
    logic              pulse_commit;
    logic              emit;
    logic              last_frame;
    logic [AXIS_W-1:0] axis;
    logic [FRM_W-1:0]  frame;
    logic [FRM_W-1:0]  frames;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_stat_t;

  // Clamp a working angle: base axis to [lo, hi] (when inverted, values below lo
  // take lo and all others hi), other axes to the full range.
  function automatic angle_t clamp_axis(input logic is_base,
                                        input logic signed [SPAN_W-1:0] v,
                                        input angle_t lo, input angle_t hi);
    logic signed [SPAN_W-1:0] l;
    logic signed [SPAN_W-1:0] h;
    angle_t r;
    if (is_base) begin
      l = $signed({{(SPAN_W-ANG_W){1'b0}}, lo});
      h = $signed({{(SPAN_W-ANG_W){1'b0}}, hi});
    end else begin
      l = '0;
      h = SPAN_W'(FULL_TENTHS);
    end
    if (v < l) r = l[ANG_W-1:0];
    else if (v > h) r = h[ANG_W-1:0];
    else r = v[ANG_W-1:0];
    return r;
  endfunction

  // Frame count: zero acts as one, large values saturate.
  function automatic logic [FRM_W-1:0] sat_frames(input logic [SUB_W-1:0] c);
    logic [FRM_W-1:0] r;
    if (c == '0) r = FRM_W'(1);
    else if (int'(c) > MAX_SUBSTEPS) r = FRM_W'(MAX_SUBSTEPS);
    else r = FRM_W'(c);
    return r;
  endfunction

endpackage

// ----- rtl/ssli_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ssli_pkg for operand widths.
module ssli_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ssli_pkg::DIV_NW-1:0]   dividend,
  input  logic [ssli_pkg::DIV_DW-1:0]   divisor,
  output logic                          done,
  output logic [ssli_pkg::DIV_NW-1:0]   quotient
);

  localparam int NW = ssli_pkg::DIV_NW;
  localparam int DW = ssli_pkg::DIV_DW;
  localparam int CW = $clog2(NW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [NW-1:0] quo_r;

  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[NW-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = (shifted >= {1'b0, den_r});
    rem_nxt = ge ? diff[DW-1:0] : shifted[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/ssli_dp.sv -----
// Datapath: joint state, move planning, interpolation and pulse mapping,
// frame buffer and output register. Depends on ssli_pkg and ssli_div.
module ssli_dp (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  ssli_pkg::dp_cmd_t                           cmd,
  output ssli_pkg::dp_stat_t                          stat,
  input  ssli_pkg::cfg_t                              cfg,
  input  ssli_pkg::angle_t [ssli_pkg::AXES-1:0]       targets,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output ssli_pkg::pulse_t [ssli_pkg::AXES-1:0]       out_pulse,
  output logic                                        out_final
);

  localparam int AXES   = ssli_pkg::AXES;
  localparam int ANG_W  = ssli_pkg::ANG_W;
  localparam int PW     = ssli_pkg::PULSE_W;
  localparam int SPAN_W = ssli_pkg::SPAN_W;
  localparam int NW     = ssli_pkg::DIV_NW;
  localparam int DW     = ssli_pkg::DIV_DW;
  localparam int US_W   = NW + 2;
  localparam int PAD    = SPAN_W - ANG_W;
  // Joint map: a * 1850 / 1800 = a + a / 36; a / 36 is taken as
  // (a * 1821) >> 16, exact for every 11-bit angle.
  localparam logic [ANG_W-1:0] RECIP_36 = ANG_W'(1821);
  localparam int RECIP_SH = 16;
  localparam logic signed [US_W-1:0] SAFE_LO = US_W'(ssli_pkg::BASE_SAFE_MIN);
  localparam logic signed [US_W-1:0] SAFE_HI = US_W'(ssli_pkg::BASE_SAFE_MAX);

  ssli_pkg::angle_t tgt_r   [AXES];
  ssli_pkg::angle_t ang_r   [AXES];
  ssli_pkg::dir_t   dir_r   [AXES];
  ssli_pkg::angle_t start_r [AXES];
  logic signed [ANG_W:0] dlt_r [AXES];
  ssli_pkg::pulse_t pulse_r [AXES];
  ssli_pkg::pulse_t [AXES-1:0] opulse_r;
  logic             ofinal_r;
  logic             ovalid_r;
  logic             neg_r;

  logic             is_base;
  ssli_pkg::angle_t cur;
  logic signed [SPAN_W-1:0] cur_s;
  logic signed [SPAN_W-1:0] delta;
  logic signed [SPAN_W-1:0] mag;
  logic signed [SPAN_W-1:0] cap;
  logic signed [SPAN_W-1:0] capped;
  ssli_pkg::dir_t   ddir;
  logic             hold;
  ssli_pkg::angle_t goal;
  logic signed [SPAN_W-1:0] gdiff;

  logic [ANG_W-1:0] dmag;
  logic signed [ANG_W:0] da;
  logic signed [PW:0]    dpp;
  logic signed [ANG_W:0] dh;
  logic [ANG_W-1:0] mag_da;
  logic [PW-1:0]    mag_dp;
  logic [ANG_W-1:0] mag_dh;

  logic          div_start;
  logic [NW-1:0] div_num;
  logic [DW-1:0] div_den;
  logic          neg_nxt;
  logic          div_done;
  logic [NW-1:0] quo;

  logic signed [SPAN_W-1:0] q_i;
  logic signed [SPAN_W-1:0] inter;
  logic signed [US_W-1:0]   q_b;
  logic signed [US_W-1:0]   us;
  logic [2*ANG_W-1:0]       frac_prod;
  ssli_pkg::pulse_t         pulse_nxt;

  assign is_base = (cmd.axis == '0);
  assign cur     = ang_r[cmd.axis];
  assign cur_s   = $signed({{PAD{1'b0}}, cur});

  // Move planning for one axis.
  always_comb begin
    delta  = $signed({{PAD{1'b0}}, tgt_r[cmd.axis]}) - cur_s;
    mag    = (delta < 0) ? -delta : delta;
    ddir   = (delta > 0) ? ssli_pkg::DIR_UP :
             ((delta < 0) ? ssli_pkg::DIR_DOWN : ssli_pkg::DIR_NONE);
    hold   = (dir_r[cmd.axis] != ssli_pkg::DIR_NONE) && (ddir != ssli_pkg::DIR_NONE) &&
             (ddir != dir_r[cmd.axis]) &&
             (mag <= $signed({{PAD{1'b0}}, cfg.reverse_deadband}));
    cap    = $signed({{PAD{1'b0}}, cfg.max_step});
    if (delta > cap) capped = cap;
    else if (delta < -cap) capped = -cap;
    else capped = delta;
    goal   = ssli_pkg::clamp_axis(is_base, cur_s + capped,
                                  cfg.base_angle_min, cfg.base_angle_max);
    gdiff  = $signed({{PAD{1'b0}}, goal}) - cur_s;
  end

  // Divider operands: interpolation step or base pulse map.
  always_comb begin
    dmag   = (dlt_r[cmd.axis] < 0) ? ANG_W'(-dlt_r[cmd.axis]) : ANG_W'(dlt_r[cmd.axis]);
    da     = $signed({1'b0, cur}) - $signed({1'b0, cfg.base_angle_min});
    dpp    = $signed({1'b0, cfg.base_pulse_at_max}) - $signed({1'b0, cfg.base_pulse_at_min});
    dh     = $signed({1'b0, cfg.base_angle_max}) - $signed({1'b0, cfg.base_angle_min});
    mag_da = (da < 0) ? ANG_W'(-da) : ANG_W'(da);
    mag_dp = (dpp < 0) ? PW'(-dpp) : PW'(dpp);
    mag_dh = (dh < 0) ? ANG_W'(-dh) : ANG_W'(dh);
    div_start = cmd.interp_start | cmd.pulse_start;
    if (cmd.interp_start) begin
      div_num = {{(NW-ANG_W){1'b0}}, dmag} * {{(NW-ssli_pkg::FRM_W){1'b0}}, cmd.frame};
      div_den = DW'(cmd.frames);
      neg_nxt = dlt_r[cmd.axis][ANG_W];
    end else begin
      div_num = mag_da * mag_dp;
      div_den = mag_dh;
      neg_nxt = da[ANG_W] ^ dpp[PW] ^ dh[ANG_W];
    end
  end

  ssli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (quo)
  );

  // Results of the two divisions, and the joint pulse map.
  always_comb begin
    q_i   = $signed({1'b0, quo[SPAN_W-2:0]});
    inter = $signed({{PAD{1'b0}}, start_r[cmd.axis]}) + (neg_r ? -q_i : q_i);
    q_b   = $signed({2'b00, quo});
    frac_prod = cur * RECIP_36;
    if (cfg.base_angle_max == cfg.base_angle_min)
      us = $signed({{(US_W-PW){1'b0}}, cfg.base_pulse_at_min});
    else
      us = (neg_r ? -q_b : q_b) + $signed({{(US_W-PW){1'b0}}, cfg.base_pulse_at_min});
    if (is_base) begin
      if (us < SAFE_LO) pulse_nxt = PW'(SAFE_LO);
      else if (us > SAFE_HI) pulse_nxt = PW'(SAFE_HI);
      else pulse_nxt = us[PW-1:0];
    end else begin
      pulse_nxt = PW'(ssli_pkg::PULSE_MIN) + {1'b0, cur} + PW'(frac_prod >> RECIP_SH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        ang_r[i] <= ANG_W'(ssli_pkg::HOME_TENTHS);
        dir_r[i] <= ssli_pkg::DIR_NONE;
      end
      ovalid_r <= 1'b0;
    end else begin
      if (cmd.plan_en && !hold && (goal != cur))
        dir_r[cmd.axis] <= (gdiff > 0) ? ssli_pkg::DIR_UP : ssli_pkg::DIR_DOWN;
      if (cmd.interp_commit)
        ang_r[cmd.axis] <= ssli_pkg::clamp_axis(is_base, inter,
                                                cfg.base_angle_min, cfg.base_angle_max);
      if (cmd.emit) ovalid_r <= 1'b1;
      else if (!out_stall) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int i = 0; i < AXES; i++) tgt_r[i] <= targets[i];
    end
    if (cmd.plan_en) begin
      start_r[cmd.axis] <= cur;
      dlt_r[cmd.axis]   <= hold ? '0 : gdiff[ANG_W:0];
    end
    if (div_start) neg_r <= neg_nxt;
    if (cmd.pulse_commit) pulse_r[cmd.axis] <= pulse_nxt;
    if (cmd.emit) begin
      for (int i = 0; i < AXES; i++) opulse_r[i] <= pulse_r[i];
      ofinal_r <= cmd.last_frame;
    end
  end

  assign stat.div_done = div_done;
  assign stat.out_free = !ovalid_r || !out_stall;
  assign out_valid     = ovalid_r;
  assign out_pulse     = opulse_r;
  assign out_final     = ofinal_r;

endmodule

// ----- rtl/ssli_ctrl.sv -----
// Sequencer: walks planning, per-axis divisions and frame emission.
// Depends on ssli_pkg.
module ssli_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ssli_pkg::SUB_W-1:0]      substep_count,
  input  ssli_pkg::dp_stat_t              stat,
  output ssli_pkg::dp_cmd_t               cmd
);

  localparam int AW = ssli_pkg::AXIS_W;
  localparam int FW = ssli_pkg::FRM_W;
  localparam logic [AW-1:0] LAST_AXIS = AW'(ssli_pkg::AXES - 1);

  ssli_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] axis_r, axis_nxt;
  logic [FW-1:0] frame_r, frame_nxt;
  logic [FW-1:0] frames_r, frames_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ssli_pkg::ST_IDLE;
      axis_r   <= '0;
      frame_r  <= '0;
      frames_r <= '0;
    end else begin
      state_r  <= state_nxt;
      axis_r   <= axis_nxt;
      frame_r  <= frame_nxt;
      frames_r <= frames_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    axis_nxt       = axis_r;
    frame_nxt      = frame_r;
    frames_nxt     = frames_r;
    cmd            = '0;
    cmd.axis       = axis_r;
    cmd.frame      = frame_r;
    cmd.frames     = frames_r;
    cmd.last_frame = (frame_r == frames_r);
    in_stall       = (state_r != ssli_pkg::ST_IDLE);
    case (state_r)
      ssli_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          axis_nxt   = '0;
          frames_nxt = ssli_pkg::sat_frames(substep_count);
          state_nxt  = ssli_pkg::ST_PLAN;
        end
      end
      ssli_pkg::ST_PLAN: begin
        cmd.plan_en = 1'b1;
        if (axis_r == LAST_AXIS) begin
          axis_nxt  = '0;
          frame_nxt = FW'(1);
          state_nxt = ssli_pkg::ST_INTERP;
        end else begin
          axis_nxt = axis_r + AW'(1);
        end
      end
      ssli_pkg::ST_INTERP: begin
        cmd.interp_start = 1'b1;
        state_nxt        = ssli_pkg::ST_INTERP_WAIT;
      end
      ssli_pkg::ST_INTERP_WAIT: begin
        if (stat.div_done) begin
          cmd.interp_commit = 1'b1;
          state_nxt         = ssli_pkg::ST_PULSE;
        end
      end
      ssli_pkg::ST_PULSE: begin
        // Only the base axis needs the divider; the joint map is combinational.
        if (axis_r == '0) begin
          cmd.pulse_start = 1'b1;
          state_nxt       = ssli_pkg::ST_PULSE_WAIT;
        end else begin
          cmd.pulse_commit = 1'b1;
          if (axis_r == LAST_AXIS) begin
            axis_nxt  = '0;
            state_nxt = ssli_pkg::ST_EMIT;
          end else begin
            axis_nxt  = axis_r + AW'(1);
            state_nxt = ssli_pkg::ST_INTERP;
          end
        end
      end
      ssli_pkg::ST_PULSE_WAIT: begin
        if (stat.div_done) begin
          cmd.pulse_commit = 1'b1;
          if (axis_r == LAST_AXIS) begin
            axis_nxt  = '0;
            state_nxt = ssli_pkg::ST_EMIT;
          end else begin
            axis_nxt  = axis_r + AW'(1);
            state_nxt = ssli_pkg::ST_INTERP;
          end
        end
      end
      ssli_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (frame_r == frames_r) begin
            state_nxt = ssli_pkg::ST_IDLE;
          end else begin
            frame_nxt = frame_r + FW'(1);
            state_nxt = ssli_pkg::ST_INTERP;
          end
        end
      end
      default: state_nxt = ssli_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/servo_slew_limited_interpolator.sv -----
// Slew-limited six-axis servo interpolator, top level.
// Holds the configuration registers; depends on ssli_pkg, ssli_ctrl, ssli_dp.
//
// Usage:
//   Input channel: one transaction carries six target angles (tenths of a
//   degree, axis 0 is the base). It is taken when in_valid is high and
//   in_stall is low; in_stall stays high until the last frame of the
//   command has been loaded into the output register.
//   Output channel: substep_count frames per command (0 acts as 1, above 32
//   saturates), each with six pulse widths in microseconds; out_final_frame
//   marks the last. A frame moves when out_valid is high and out_stall low.
//   Configuration: cfg_ready is always high; write only while idle.
//   Sequence: the accept, then planning of each axis in turn; then for each
//   frame the base axis makes two passes through the shared 23-step divider
//   (interpolation step, then pulse map), each other axis one pass plus its
//   multiply-based pulse map, and a last step loads the output register.
//   Stall: a stalled frame holds in the output register while the next frame
//   is computed; the sequencer waits before loading over it.
//   Reset: joints return to 900 tenths, directions clear, registers take
//   their defaults; no clearing pass is needed.
module servo_slew_limited_interpolator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  ssli_pkg::angle_t                 in_target_axis0,
  input  ssli_pkg::angle_t                 in_target_axis1,
  input  ssli_pkg::angle_t                 in_target_axis2,
  input  ssli_pkg::angle_t                 in_target_axis3,
  input  ssli_pkg::angle_t                 in_target_axis4,
  input  ssli_pkg::angle_t                 in_target_axis5,
  output logic                             out_valid,
  input  logic                             out_stall,
  output ssli_pkg::pulse_t                 out_pulse_axis0,
  output ssli_pkg::pulse_t                 out_pulse_axis1,
  output ssli_pkg::pulse_t                 out_pulse_axis2,
  output ssli_pkg::pulse_t                 out_pulse_axis3,
  output ssli_pkg::pulse_t                 out_pulse_axis4,
  output ssli_pkg::pulse_t                 out_pulse_axis5,
  output logic                             out_final_frame,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ssli_pkg::IDX_W-1:0]       cfg_index,
  input  logic [ssli_pkg::PULSE_W-1:0]     cfg_data
);

  localparam int ANG_W = ssli_pkg::ANG_W;

  ssli_pkg::cfg_t                          cfg_r;
  logic [ssli_pkg::SUB_W-1:0]              substep_r;
  ssli_pkg::dp_cmd_t                       cmd;
  ssli_pkg::dp_stat_t                      stat;
  ssli_pkg::angle_t [ssli_pkg::AXES-1:0]   targets;
  ssli_pkg::pulse_t [ssli_pkg::AXES-1:0]   pulses;

  assign cfg_ready = 1'b1;

  // Register writes; an unused index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_step          <= ANG_W'(50);
      substep_r               <= ssli_pkg::SUB_W'(8);
      cfg_r.reverse_deadband  <= ANG_W'(20);
      cfg_r.base_angle_min    <= ANG_W'(0);
      cfg_r.base_angle_max    <= ANG_W'(1800);
      cfg_r.base_pulse_at_min <= ssli_pkg::PULSE_W'(500);
      cfg_r.base_pulse_at_max <= ssli_pkg::PULSE_W'(2500);
    end else if (cfg_valid && cfg_ready) begin
      case (ssli_pkg::reg_idx_t'(cfg_index))
        ssli_pkg::REG_MAX_STEP:          cfg_r.max_step <= cfg_data[ANG_W-1:0];
        ssli_pkg::REG_SUBSTEP_COUNT:     substep_r <= cfg_data[ssli_pkg::SUB_W-1:0];
        ssli_pkg::REG_REVERSE_DEADBAND:  cfg_r.reverse_deadband <= cfg_data[ANG_W-1:0];
        ssli_pkg::REG_BASE_ANGLE_MIN:    cfg_r.base_angle_min <= cfg_data[ANG_W-1:0];
        ssli_pkg::REG_BASE_ANGLE_MAX:    cfg_r.base_angle_max <= cfg_data[ANG_W-1:0];
        ssli_pkg::REG_BASE_PULSE_AT_MIN: cfg_r.base_pulse_at_min <= cfg_data;
        ssli_pkg::REG_BASE_PULSE_AT_MAX: cfg_r.base_pulse_at_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // Gather the per-axis ports into lanes.
  assign targets[0] = in_target_axis0;
  assign targets[1] = in_target_axis1;
  assign targets[2] = in_target_axis2;
  assign targets[3] = in_target_axis3;
  assign targets[4] = in_target_axis4;
  assign targets[5] = in_target_axis5;

  ssli_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .substep_count (substep_r),
    .stat          (stat),
    .cmd           (cmd)
  );

  ssli_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg       (cfg_r),
    .targets   (targets),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pulse (pulses),
    .out_final (out_final_frame)
  );

  assign out_pulse_axis0 = pulses[0];
  assign out_pulse_axis1 = pulses[1];
  assign out_pulse_axis2 = pulses[2];
  assign out_pulse_axis3 = pulses[3];
  assign out_pulse_axis4 = pulses[4];
  assign out_pulse_axis5 = pulses[5];

endmodule

// ----- rtl/ssli_check.sv -----
// Port-level checker for the servo interpolator, bound to the top level.
// Depends on ssli_pkg and servo_slew_limited_interpolator_assert.svh.
`include "servo_slew_limited_interpolator_assert.svh"

module ssli_check (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [ssli_pkg::PULSE_W-1:0]  out_pulse_axis0,
  input logic [ssli_pkg::PULSE_W-1:0]  out_pulse_axis1,
  input logic                          out_final_frame
);

  // A stalled frame must hold.
  `SSLI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_pulse_axis0) && $stable(out_final_frame), "stalled frame changed")

  // A new command keeps the input side closed while it is planned.
  `SSLI_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input open right after a transaction")

  // Base pulse stays within the safe limits.
  `SSLI_ASSERT_NOW(a_base_safe, out_valid, (out_pulse_axis0 >= ssli_pkg::BASE_SAFE_MIN) && (out_pulse_axis0 <= ssli_pkg::BASE_SAFE_MAX), "base pulse outside safe limits")

  // The axis 1 joint pulse stays within the mapped span.
  `SSLI_ASSERT_NOW(a_axis_span, out_valid, (out_pulse_axis1 >= ssli_pkg::PULSE_MIN) && (out_pulse_axis1 <= ssli_pkg::PULSE_MAX), "axis pulse outside span")

endmodule

bind servo_slew_limited_interpolator ssli_check u_check (.*);
